/* hdl/msm_pkg.sv */
package msm_pkg;

    localparam logic [16:0] ONE_Q16         = 17'h10000;
    localparam logic [16:0] SWAP_MIN_VOLUME = 17'd13107;

    localparam logic [2:0] REG_IDLE_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_SWING_GAIN      = 3'd1;
    localparam logic [2:0] REG_CROSSFADE_LOW   = 3'd2;
    localparam logic [2:0] REG_CROSSFADE_GAIN  = 3'd3;
    localparam logic [2:0] REG_GRAVITY_GAIN    = 3'd4;
    localparam logic [2:0] REG_HUM_BASE_VOLUME = 3'd5;
    localparam logic [2:0] REG_HUM_DUCK_DEPTH  = 3'd6;
    localparam logic [2:0] REG_SWAP_COOLDOWN   = 3'd7;

    typedef struct packed {
        logic [15:0]        idle_threshold;
        logic [15:0]        swing_gain;
        logic [15:0]        crossfade_low;
        logic [15:0]        crossfade_gain;
        logic signed [15:0] gravity_gain;
        logic [13:0]        hum_base_volume;
        logic [15:0]        hum_duck_depth;
        logic [15:0]        swap_cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic               idle_pos;
        logic [15:0]        idle_diff;
        logic               cf_pos;
        logic [15:0]        cf_diff;
        logic signed [15:0] orientation_term;
        logic               burst_flag;
        logic [31:0]        time_ms;
    } t_item;

    typedef struct packed {
        logic [13:0] swing_low_volume;
        logic [13:0] swing_high_volume;
        logic [13:0] hum_volume;
        logic        burst_trigger;
        logic        swap_request;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MASTER,
        S_BASE,
        S_GRAV,
        S_MIX,
        S_PROD,
        S_HUM,
        S_DONE
    } t_state;

    function automatic logic [16:0] clamp_q16(input logic signed [36:0] v);
        logic [16:0] r;
        if (v[36]) begin
            r = 17'd0;
        end else if (v > 37'sh10000) begin
            r = ONE_Q16;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

/* hdl/msm_front.sv */
module msm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msm_pkg::t_cfg        i_cfg,
    input  logic                 push,
    output logic                 full,
    input  logic [15:0]          i_kinetic_energy,
    input  logic signed [15:0]   i_orientation_term,
    input  logic                 i_burst_flag,
    input  logic [31:0]          i_time_ms,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output msm_pkg::t_item       o_q_item
);
    import msm_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign full     = r_valid && i_q_full;
    assign accept   = push && !full;
    assign o_q_push = r_valid;
    assign o_q_item = r_item;

    always_comb begin
        n_item                  = r_item;
        n_item.idle_pos         = i_kinetic_energy > i_cfg.idle_threshold;
        n_item.idle_diff        = i_kinetic_energy - i_cfg.idle_threshold;
        n_item.cf_pos           = i_kinetic_energy > i_cfg.crossfade_low;
        n_item.cf_diff          = i_kinetic_energy - i_cfg.crossfade_low;
        n_item.orientation_term = i_orientation_term;
        n_item.burst_flag       = i_burst_flag;
        n_item.time_ms          = i_time_ms;
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_q_full) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* hdl/msm_queue.sv */
module msm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  msm_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output msm_pkg::t_item o_item,
    output logic           o_empty
);
    import msm_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* hdl/msm_back.sv */
module msm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msm_pkg::t_cfg    i_cfg,
    input  logic             i_q_empty,
    input  msm_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_out_valid,
    output msm_pkg::t_result o_result
);
    import msm_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_item               r_item;
    logic signed [35:0]  r_prod;
    logic [16:0]         r_master;
    logic [16:0]         r_base;
    logic [16:0]         r_mix;
    logic [16:0]         r_duck;
    logic [32:0]         r_pmix;
    logic                r_swap_pending;
    logic                r_was_moving;
    logic [31:0]         r_last_motion;
    logic                r_out_valid;
    t_result             r_result;

    logic signed [17:0]  mul_a;
    logic signed [17:0]  mul_b;
    logic signed [35:0]  mul_p;
    logic signed [36:0]  mix_sum;
    logic [32:0]         low_x;
    logic [46:0]         low_y;
    logic [46:0]         high_y;
    logic [31:0]         idle_time;
    logic                out_free;
    logic                finish;
    logic                req;
    logic                n_swap_pending;
    logic                n_was_moving;
    t_result             n_result;

    assign out_free    = !r_out_valid || i_pop;
    assign finish      = (r_state == S_DONE) && out_free;
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   n_state = i_q_empty ? S_IDLE : S_MASTER;
            S_MASTER: n_state = S_BASE;
            S_BASE:   n_state = S_GRAV;
            S_GRAV:   n_state = S_MIX;
            S_MIX:    n_state = S_PROD;
            S_PROD:   n_state = S_HUM;
            S_HUM:    n_state = S_DONE;
            S_DONE:   n_state = out_free ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a = 18'sd0;
        mul_b = 18'sd0;
        case (r_state)
            S_MASTER: begin
                mul_a = r_item.idle_pos ? $signed({2'b00, r_item.idle_diff}) : 18'sd0;
                mul_b = $signed({2'b00, i_cfg.swing_gain});
            end
            S_BASE: begin
                mul_a = r_item.cf_pos ? $signed({2'b00, r_item.cf_diff}) : 18'sd0;
                mul_b = $signed({2'b00, i_cfg.crossfade_gain});
            end
            S_GRAV: begin
                mul_a = {{2{r_item.orientation_term[15]}}, r_item.orientation_term};
                mul_b = {{2{i_cfg.gravity_gain[15]}}, i_cfg.gravity_gain};
            end
            S_MIX: begin
                mul_a = $signed({1'b0, r_master});
                mul_b = $signed({2'b00, i_cfg.hum_duck_depth});
            end
            S_PROD: begin
                mul_a = $signed({1'b0, r_master});
                mul_b = $signed({1'b0, r_mix});
            end
            S_HUM: begin
                mul_a = $signed({4'b0000, i_cfg.hum_base_volume});
                mul_b = $signed({1'b0, ONE_Q16 - r_duck});
            end
            default: begin
                mul_a = 18'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mix_sum = $signed({20'd0, r_base}) + {r_prod[35], (r_prod >>> 12)};

    assign low_x  = {r_master, 16'd0} - r_pmix;
    assign low_y  = {low_x, 14'd0} - {14'd0, low_x};
    assign high_y = {r_pmix, 14'd0} - {14'd0, r_pmix};

    assign idle_time = r_item.time_ms - r_last_motion;

    always_comb begin
        req            = 1'b0;
        n_swap_pending = r_swap_pending || (r_master > SWAP_MIN_VOLUME);
        n_was_moving   = r_was_moving;
        if (r_master != 17'd0) begin
            n_was_moving = 1'b1;
        end else if (r_was_moving) begin
            n_was_moving = 1'b0;
        end else if (n_swap_pending && (idle_time >= {16'd0, i_cfg.swap_cooldown_ms})) begin
            req            = 1'b1;
            n_swap_pending = 1'b0;
        end
        n_result.swing_low_volume  = low_y[45:32];
        n_result.swing_high_volume = high_y[45:32];
        n_result.hum_volume        = r_prod[29:16];
        n_result.burst_trigger     = r_item.burst_flag;
        n_result.swap_request      = req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_swap_pending <= 1'b0;
            r_was_moving   <= 1'b0;
            r_last_motion  <= 32'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_swap_pending <= n_swap_pending;
                r_was_moving   <= n_was_moving;
                if (r_master != 17'd0) begin
                    r_last_motion <= r_item.time_ms;
                end
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (r_state != S_DONE) begin
            r_prod <= mul_p;
        end
        case (r_state)
            S_BASE:  r_master <= clamp_q16({r_prod[35], r_prod});
            S_GRAV:  r_base   <= clamp_q16({r_prod[35], r_prod});
            S_MIX:   r_mix    <= clamp_q16(mix_sum);
            S_PROD:  r_duck   <= r_prod[32:16];
            S_HUM:   r_pmix   <= r_prod[32:0];
            default: r_duck   <= r_duck;
        endcase
        if (finish) begin
            r_result <= n_result;
        end
    end

endmodule

/* hdl/motion_swing_sound_mixer.sv */
// Swing sound mixer driven by motion samples.
// Input channel: a word of kinetic energy, orientation term, burst flag and
// timestamp is taken when push is high and full is low.
// Result channel: while empty is low the oldest result word is on the output
// ports, and it is taken when pop is high.
// Each word passes through an input stage, a two-word queue and a compute
// engine that runs six steps on one shared 18 by 18 multiplier and then
// writes an output register. The engine works on one word at a time, and
// the input stage and the queue take new words while it does so.
// A stalled receiver holds the output register; the engine finishes the next
// word and waits, and the input keeps taking words until the queue and the
// input stage are full.
// Configuration registers sit on the APB port at byte address 4 times their
// index. The user must write them only while the block holds no words; the
// block does not enforce this. Synchronous reset restores the register
// defaults, clears the swap tracker and empties every stage.
module motion_swing_sound_mixer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 push,
    output logic                 full,
    input  logic [15:0]          i_kinetic_energy,
    input  logic signed [15:0]   i_orientation_term,
    input  logic                 i_burst_flag,
    input  logic [31:0]          i_time_ms,
    output logic                 empty,
    input  logic                 pop,
    output logic [13:0]          o_swing_low_volume,
    output logic [13:0]          o_swing_high_volume,
    output logic [13:0]          o_hum_volume,
    output logic                 o_burst_trigger,
    output logic                 o_swap_request
);
    import msm_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic    [2:0] cfg_idx;
    logic    q_full;
    logic    q_push;
    t_item   q_in_item;
    logic    q_pop;
    t_item   q_out_item;
    logic    q_empty;
    logic    out_valid;
    t_result result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_threshold   <= 16'd256;
            r_cfg.swing_gain       <= 16'd256;
            r_cfg.crossfade_low    <= 16'd256;
            r_cfg.crossfade_gain   <= 16'd256;
            r_cfg.gravity_gain     <= 16'sd0;
            r_cfg.hum_base_volume  <= 14'd8192;
            r_cfg.hum_duck_depth   <= 16'd32768;
            r_cfg.swap_cooldown_ms <= 16'd500;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IDLE_THRESHOLD:  r_cfg.idle_threshold   <= pwdata[15:0];
                REG_SWING_GAIN:      r_cfg.swing_gain       <= pwdata[15:0];
                REG_CROSSFADE_LOW:   r_cfg.crossfade_low    <= pwdata[15:0];
                REG_CROSSFADE_GAIN:  r_cfg.crossfade_gain   <= pwdata[15:0];
                REG_GRAVITY_GAIN:    r_cfg.gravity_gain     <= $signed(pwdata[15:0]);
                REG_HUM_BASE_VOLUME: r_cfg.hum_base_volume  <= pwdata[13:0];
                REG_HUM_DUCK_DEPTH:  r_cfg.hum_duck_depth   <= pwdata[15:0];
                REG_SWAP_COOLDOWN:   r_cfg.swap_cooldown_ms <= pwdata[15:0];
                default:             r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_IDLE_THRESHOLD:  prdata = {16'd0, r_cfg.idle_threshold};
            REG_SWING_GAIN:      prdata = {16'd0, r_cfg.swing_gain};
            REG_CROSSFADE_LOW:   prdata = {16'd0, r_cfg.crossfade_low};
            REG_CROSSFADE_GAIN:  prdata = {16'd0, r_cfg.crossfade_gain};
            REG_GRAVITY_GAIN:    prdata = {{16{r_cfg.gravity_gain[15]}}, r_cfg.gravity_gain};
            REG_HUM_BASE_VOLUME: prdata = {18'd0, r_cfg.hum_base_volume};
            REG_HUM_DUCK_DEPTH:  prdata = {16'd0, r_cfg.hum_duck_depth};
            REG_SWAP_COOLDOWN:   prdata = {16'd0, r_cfg.swap_cooldown_ms};
            default:             prdata = 32'd0;
        endcase
    end

    msm_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .push               (push),
        .full               (full),
        .i_kinetic_energy   (i_kinetic_energy),
        .i_orientation_term (i_orientation_term),
        .i_burst_flag       (i_burst_flag),
        .i_time_ms          (i_time_ms),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_item           (q_in_item)
    );

    msm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    msm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign empty               = !out_valid;
    assign o_swing_low_volume  = result.swing_low_volume;
    assign o_swing_high_volume = result.swing_high_volume;
    assign o_hum_volume        = result.hum_volume;
    assign o_burst_trigger     = result.burst_trigger;
    assign o_swap_request      = result.swap_request;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import msm_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int SWINGS_PER_PHASE = 145;

    typedef struct {
        logic [15:0]        energy;
        logic signed [15:0] orient;
        logic               burst;
        logic [31:0]        stamp;
        bit                 wait_drain;
    } t_sample;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push = 1'b0;
    logic               full;
    logic [15:0]        i_kinetic_energy = '0;
    logic signed [15:0] i_orientation_term = '0;
    logic               i_burst_flag = 1'b0;
    logic [31:0]        i_time_ms = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [13:0]        o_swing_low_volume;
    logic [13:0]        o_swing_high_volume;
    logic [13:0]        o_hum_volume;
    logic               o_burst_trigger;
    logic               o_swap_request;

    t_sample     pending_samples[$];
    t_result     expected_volumes[$];
    t_sample     on_port;
    t_cfg        cfg;
    bit          swap_armed = 1'b0;
    bit          moving = 1'b0;
    logic [31:0] motion_stamp = '0;
    logic [31:0] clock_ms = '0;
    int          errors = 0;
    bit          steady = 1'b0;
    bit          drained = 1'b1;
    int          send_gap = 0;
    int          pop_stall = 0;

    motion_swing_sound_mixer u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .push                (push),
        .full                (full),
        .i_kinetic_energy    (i_kinetic_energy),
        .i_orientation_term  (i_orientation_term),
        .i_burst_flag        (i_burst_flag),
        .i_time_ms           (i_time_ms),
        .empty               (empty),
        .pop                 (pop),
        .o_swing_low_volume  (o_swing_low_volume),
        .o_swing_high_volume (o_swing_high_volume),
        .o_hum_volume        (o_hum_volume),
        .o_burst_trigger     (o_burst_trigger),
        .o_swap_request      (o_swap_request)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [16:0] ramp_q16(logic [15:0] level, logic [15:0] thr,
                                             logic [15:0] gain);
        logic [31:0] prod;
        if (level <= thr) begin
            return 17'd0;
        end
        prod = (32'(level) - 32'(thr)) * 32'(gain);
        return (prod > 32'(ONE_Q16)) ? ONE_Q16 : prod[16:0];
    endfunction

    function automatic t_result mix_sample(t_sample s);
        t_result            r;
        logic [16:0]        master;
        logic [16:0]        base;
        logic signed [31:0] grav_prod;
        logic signed [33:0] mix_sum;
        logic [16:0]        mix;
        logic [63:0]        low;
        logic [63:0]        high;
        logic [63:0]        duck;
        logic [63:0]        hum;
        logic [31:0]        idle_ms;
        master = ramp_q16(s.energy, cfg.idle_threshold, cfg.swing_gain);
        base = ramp_q16(s.energy, cfg.crossfade_low, cfg.crossfade_gain);
        grav_prod = 32'(s.orient) * 32'(cfg.gravity_gain);
        // An arithmetic shift floors toward minus infinity.
        mix_sum = $signed({17'b0, base}) + (grav_prod >>> 12);
        if (mix_sum < 0) begin
            mix = 17'd0;
        end else if (mix_sum > 34'sd65536) begin
            mix = ONE_Q16;
        end else begin
            mix = mix_sum[16:0];
        end
        low = (64'(master) * (64'(ONE_Q16) - 64'(mix)) * 64'd16383) >> 32;
        high = (64'(master) * 64'(mix) * 64'd16383) >> 32;
        duck = (64'(master) * 64'(cfg.hum_duck_depth)) >> 16;
        hum = (64'(cfg.hum_base_volume) * (64'(ONE_Q16) - duck)) >> 16;
        r.swing_low_volume = low[13:0];
        r.swing_high_volume = high[13:0];
        r.hum_volume = hum[13:0];
        r.burst_trigger = s.burst;
        r.swap_request = 1'b0;
        if (master > SWAP_MIN_VOLUME) begin
            swap_armed = 1'b1;
        end
        if (master != 17'd0) begin
            moving = 1'b1;
            motion_stamp = s.stamp;
        end else if (moving) begin
            moving = 1'b0;
        end else if (swap_armed) begin
            idle_ms = s.stamp - motion_stamp;
            if (idle_ms >= 32'(cfg.swap_cooldown_ms)) begin
                r.swap_request = 1'b1;
                swap_armed = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic t_sample next_sample(logic [15:0] energy, logic [31:0] step);
        t_sample s;
        clock_ms = clock_ms + step;
        s.energy = energy;
        if ($urandom_range(0, 4) == 0) begin
            s.orient = 16'($urandom());
        end else begin
            s.orient = 16'($urandom_range(0, 32768) - 16384);
        end
        s.burst = 1'($urandom_range(0, 1));
        s.stamp = clock_ms;
        s.wait_drain = ($urandom_range(0, 99) == 0);
        return s;
    endfunction

    task automatic queue_fixed(logic [15:0] energy, logic signed [15:0] orient,
                               logic burst, logic [31:0] stamp, bit wait_drain);
        pending_samples.push_back('{energy, orient, burst, stamp, wait_drain});
    endtask

    // Most words form swings: a run of motion followed by a run of rest long
    // enough to reach the cooldown now and then. The rest are random noise.
    task automatic queue_swings(int count);
        int          made;
        int          moves;
        int          rests;
        int unsigned headroom;
        logic [15:0] energy;
        logic [31:0] step;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 4) == 0) begin
                step = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000);
                pending_samples.push_back(next_sample(16'($urandom()), step));
                made++;
            end else begin
                moves = $urandom_range(1, 8);
                rests = $urandom_range(1, 6);
                headroom = 32'hFFFF - 32'(cfg.idle_threshold);
                for (int k = 0; k < moves + rests; k++) begin
                    if (k < moves) begin
                        if (headroom == 0) begin
                            energy = 16'hFFFF;
                        end else if ($urandom_range(0, 1) == 1) begin
                            energy = cfg.idle_threshold +
                                     16'($urandom_range(1, (headroom > 600) ? 600 : headroom));
                        end else begin
                            energy = cfg.idle_threshold + 16'($urandom_range(1, headroom));
                        end
                        step = $urandom_range(1, 20);
                    end else begin
                        energy = 16'($urandom_range(0, cfg.idle_threshold));
                        if ($urandom_range(0, 15) == 0) begin
                            step = $urandom();
                        end else begin
                            step = $urandom_range(1, cfg.swap_cooldown_ms / 3 + 20);
                        end
                    end
                    pending_samples.push_back(next_sample(energy, step));
                    made++;
                end
            end
        end
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= {16'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_IDLE_THRESHOLD:  cfg.idle_threshold = value;
            REG_SWING_GAIN:      cfg.swing_gain = value;
            REG_CROSSFADE_LOW:   cfg.crossfade_low = value;
            REG_CROSSFADE_GAIN:  cfg.crossfade_gain = value;
            REG_GRAVITY_GAIN:    cfg.gravity_gain = $signed(value);
            REG_HUM_BASE_VOLUME: cfg.hum_base_volume = value[13:0];
            REG_HUM_DUCK_DEPTH:  cfg.hum_duck_depth = value;
            REG_SWAP_COOLDOWN:   cfg.swap_cooldown_ms = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] idle, logic [15:0] sgain, logic [15:0] cf_low,
                             logic [15:0] cf_gain, logic [15:0] grav, logic [15:0] hum,
                             logic [15:0] depth, logic [15:0] cooldown);
        write_reg(REG_IDLE_THRESHOLD, idle);
        write_reg(REG_SWING_GAIN, sgain);
        write_reg(REG_CROSSFADE_LOW, cf_low);
        write_reg(REG_CROSSFADE_GAIN, cf_gain);
        write_reg(REG_GRAVITY_GAIN, grav);
        write_reg(REG_HUM_BASE_VOLUME, hum);
        write_reg(REG_HUM_DUCK_DEPTH, depth);
        write_reg(REG_SWAP_COOLDOWN, cooldown);
    endtask

    always @(negedge i_clk) begin
        drained = (expected_volumes.size() == 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_volumes.push_back(mix_sample(on_port));
            end
            if (!push || !full) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (pending_samples.size() > 0 &&
                             (!pending_samples[0].wait_drain || (drained && !push))) begin
                    on_port = pending_samples.pop_front();
                    i_kinetic_energy <= on_port.energy;
                    i_orientation_term <= on_port.orient;
                    i_burst_flag <= on_port.burst;
                    i_time_ms <= on_port.stamp;
                    push <= 1'b1;
                    send_gap = idle_cycles();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_volumes.size() == 0) begin
                    errors++;
                    $display("%0t: word with none expected, actual low %0d high %0d hum %0d",
                             $time, o_swing_low_volume, o_swing_high_volume, o_hum_volume);
                end else begin
                    want = expected_volumes.pop_front();
                    check_field("swing_low_volume", int'(want.swing_low_volume),
                                int'(o_swing_low_volume));
                    check_field("swing_high_volume", int'(want.swing_high_volume),
                                int'(o_swing_high_volume));
                    check_field("hum_volume", int'(want.hum_volume), int'(o_hum_volume));
                    check_field("burst_trigger", int'(want.burst_trigger),
                                int'(o_burst_trigger));
                    check_field("swap_request", int'(want.swap_request),
                                int'(o_swap_request));
                end
                pop_stall = idle_cycles();
            end
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        cfg.idle_threshold = 16'd256;
        cfg.swing_gain = 16'd256;
        cfg.crossfade_low = 16'd256;
        cfg.crossfade_gain = 16'd256;
        cfg.gravity_gain = 16'sd0;
        cfg.hum_base_volume = 14'd8192;
        cfg.hum_duck_depth = 16'd32768;
        cfg.swap_cooldown_ms = 16'd500;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: ;
                1: write_all(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h3FFF,
                             16'hFFFF, 16'h0000);
                2: write_all(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000,
                             16'h0000, 16'hFFFF);
                3: write_all(16'd128, 16'd512, 16'd512, 16'd64, 16'd16384, 16'h3FFF,
                             16'hFFFF, 16'd100);
                default: write_all(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                                   16'($urandom_range(0, 4096)), 16'($urandom_range(0, 1024)),
                                   (phase == 4) ? -16'sd16384 : 16'($urandom()),
                                   16'($urandom()), 16'($urandom()),
                                   16'($urandom_range(0, 1500)));
            endcase
            @(negedge i_clk);
            steady = (phase == 3 || phase == 6);
            if (phase == 0) begin
                queue_fixed(16'h0000, 16'sd0, 1'b0, 32'd0, 1'b0);
                queue_fixed(16'hFFFF, 16'sd16384, 1'b1, 32'd10, 1'b0);
                queue_fixed(16'd256, -16'sd16384, 1'b0, 32'd20, 1'b0);
                queue_fixed(16'd257, 16'sh7FFF, 1'b1, 32'd30, 1'b0);
                queue_fixed(16'h0000, 16'sh8000, 1'b0, 32'd40, 1'b0);
                queue_fixed(16'h0000, 16'sd0, 1'b0, 32'd100, 1'b0);
                queue_fixed(16'h0000, 16'sd0, 1'b1, 32'd530, 1'b0);
                queue_fixed(16'h0000, 16'sd0, 1'b0, 32'd2000, 1'b1);
                queue_fixed(16'hFFFF, 16'sd0, 1'b0, 32'hFFFF_FFF0, 1'b0);
                queue_fixed(16'h0000, 16'sd0, 1'b0, 32'd5, 1'b0);
                queue_fixed(16'h0000, 16'sd0, 1'b0, 32'd484, 1'b0);
                queue_fixed(16'h8000, -16'sd16384, 1'b1, 32'h7FFF_FFFF, 1'b0);
                queue_fixed(16'h0200, 16'sh8000, 1'b0, 32'hFFFF_FFFF, 1'b0);
                queue_fixed(16'h0000, 16'sd1, 1'b1, 32'd0, 1'b0);
                queue_fixed(16'h0000, -16'sd1, 1'b0, 32'd100, 1'b0);
                queue_fixed(16'h0000, 16'sd0, 1'b1, 32'h8000_0000, 1'b0);
                clock_ms = 32'h8000_1000;
            end
            queue_swings(SWINGS_PER_PHASE);
            do @(negedge i_clk);
            while (pending_samples.size() != 0 || push || expected_volumes.size() != 0);
            repeat (DRAIN_CYCLES) @(negedge i_clk);
        end
        if (errors == 0 && expected_volumes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
